>>> sv/window_rank_numbering_core_defines.svh
// Assertion macros shared by the checker file.
`ifndef WINDOW_RANK_NUMBERING_CORE_DEFINES_SVH
`define WINDOW_RANK_NUMBERING_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WRN_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WRN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/wnr_pkg.sv
`default_nettype none
package wnr_pkg;

    localparam int ROW_BITS      = 32;
    localparam int FRACTION_BITS = 16;
    localparam int PCT_BITS      = FRACTION_BITS + 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int STEP_BITS     = $clog2(FRACTION_BITS + 1);

    typedef logic [ROW_BITS-1:0] row_t;
    typedef logic [PCT_BITS-1:0] pct_t;

    localparam row_t ROW_MAX = '1;
    localparam pct_t PCT_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    // How percent rank is formed for one row.
    typedef enum logic [1:0] {
        PCT_ZERO,
        PCT_FULL,
        PCT_DIVIDE
    } pct_kind_t;

    typedef struct packed {
        row_t      row_index;
        row_t      gap_rank;
        row_t      compact_rank;
        row_t      numer;
        row_t      denom;
        pct_kind_t kind;
    } work_item_t;

endpackage
`default_nettype wire

>>> sv/wnr_front.sv
`default_nettype none
module wnr_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire                  s_partition_start,
    input  wire                  s_ties_previous,
    input  wnr_pkg::row_t        s_partition_rows,
    output logic                 push_valid,
    input  wire                  push_ready,
    output wnr_pkg::work_item_t  push_item
);
    import wnr_pkg::*;

    row_t position_reg, position_next;
    row_t gap_reg, gap_next;
    row_t dense_reg, dense_next;
    row_t pos_inc, dense_inc;
    logic restart;
    logic accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    // First row after reset counts as a partition start.
    assign restart   = s_partition_start || (position_reg == '0);
    assign pos_inc   = (position_reg == ROW_MAX) ? position_reg : position_reg + 1'b1;
    assign dense_inc = (dense_reg == ROW_MAX) ? dense_reg : dense_reg + 1'b1;

    always_comb begin
        if (restart) begin
            position_next = row_t'(1);
            gap_next      = row_t'(1);
            dense_next    = row_t'(1);
        end else begin
            position_next = pos_inc;
            gap_next      = s_ties_previous ? gap_reg : pos_inc;
            dense_next    = s_ties_previous ? dense_reg : dense_inc;
        end
    end

    always_comb begin
        push_item.row_index    = position_next;
        push_item.gap_rank     = gap_next;
        push_item.compact_rank = dense_next;
        push_item.numer        = gap_next - 1'b1;
        push_item.denom        = s_partition_rows - 1'b1;
        // gap >= rows is the same test as gap-1 >= rows-1 once rows >= 2
        if (s_partition_rows <= row_t'(1)) begin
            push_item.kind = PCT_ZERO;
        end else if (gap_next >= s_partition_rows) begin
            push_item.kind = PCT_FULL;
        end else begin
            push_item.kind = PCT_DIVIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            gap_reg      <= '0;
            dense_reg    <= '0;
        end else if (accept) begin
            position_reg <= position_next;
            gap_reg      <= gap_next;
            dense_reg    <= dense_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/wnr_queue.sv
`default_nettype none
module wnr_queue (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push_valid,
    output logic                 push_ready,
    input  wnr_pkg::work_item_t  push_item,
    output logic                 pop_valid,
    input  wire                  pop_ready,
    output wnr_pkg::work_item_t  pop_item
);
    import wnr_pkg::*;

    work_item_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0]  count_reg;
    logic                  do_push, do_pop;

    function automatic logic [QPTR_BITS-1:0] ptr_step(input logic [QPTR_BITS-1:0] p);
        return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign push_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_step(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_step(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/wnr_back.sv
`default_nettype none
module wnr_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  pop_valid,
    output logic                 pop_ready,
    input  wnr_pkg::work_item_t  pop_item,
    output logic                 m_valid,
    input  wire                  m_ready,
    output wnr_pkg::row_t        m_row_index,
    output wnr_pkg::row_t        m_gap_rank,
    output wnr_pkg::row_t        m_compact_rank,
    output wnr_pkg::pct_t        m_frac_rank
);
    import wnr_pkg::*;

    logic                     busy_reg;
    logic [STEP_BITS-1:0]     steps_reg;
    row_t                     row_reg, gap_reg, dense_reg;
    row_t                     rem_reg, den_reg;
    logic [FRACTION_BITS-1:0] quo_reg;
    pct_kind_t                kind_reg;
    logic                     m_valid_reg;
    row_t                     m_row_reg, m_gap_reg, m_dense_reg;
    pct_t                     m_pct_reg;

    logic                     out_free, finish, take;
    logic [ROW_BITS:0]        shl, diff;
    logic                     ge;
    pct_t                     pct_value;

    assign out_free  = !m_valid_reg || m_ready;
    assign finish    = busy_reg && (steps_reg == '0) && out_free;
    assign pop_ready = !busy_reg || finish;
    assign take      = pop_valid && pop_ready;

    // One quotient bit per cycle, restoring.
    assign shl  = {rem_reg, 1'b0};
    assign diff = shl - {1'b0, den_reg};
    assign ge   = (shl >= {1'b0, den_reg});

    always_comb begin
        case (kind_reg)
            PCT_ZERO:   pct_value = '0;
            PCT_FULL:   pct_value = PCT_ONE;
            PCT_DIVIDE: pct_value = {1'b0, quo_reg};
            default:    pct_value = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            row_reg   <= pop_item.row_index;
            gap_reg   <= pop_item.gap_rank;
            dense_reg <= pop_item.compact_rank;
            rem_reg   <= pop_item.numer;
            den_reg   <= pop_item.denom;
            kind_reg  <= pop_item.kind;
            quo_reg   <= '0;
        end else if (busy_reg && (steps_reg != '0)) begin
            rem_reg <= ge ? diff[ROW_BITS-1:0] : shl[ROW_BITS-1:0];
            quo_reg <= {quo_reg[FRACTION_BITS-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            steps_reg <= '0;
        end else if (take) begin
            busy_reg  <= 1'b1;
            steps_reg <= (pop_item.kind == PCT_DIVIDE) ? STEP_BITS'(FRACTION_BITS) : '0;
        end else if (finish) begin
            busy_reg <= 1'b0;
        end else if (busy_reg && (steps_reg != '0)) begin
            steps_reg <= steps_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_row_reg   <= row_reg;
            m_gap_reg   <= gap_reg;
            m_dense_reg <= dense_reg;
            m_pct_reg   <= pct_value;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_row_index    = m_row_reg;
    assign m_gap_rank     = m_gap_reg;
    assign m_compact_rank = m_dense_reg;
    assign m_frac_rank    = m_pct_reg;

endmodule
`default_nettype wire

>>> sv/window_rank_numbering_core.sv
// Channel  | Direction | Beat contents
// ---------+-----------+--------------------------------------------------------
// s_       | in        | partition_start, ties_previous, partition_rows[31:0]
// m_       | out       | row_index, gap_rank, compact_rank [31:0], frac_rank[16:0]
//
// Front takes one beat per cycle while the 2-entry queue has room.
// s_ beat to m_valid: queue write, back-end load, then, only when it divides,
// 16 quotient bits one per cycle, then hand-off to the output register.
// Back takes its next row in the hand-off cycle: one row per cycle without a
// divide while m_ does not stall; with one, the bit-serial divider sets the rate.
// Reset (aresetn low, synchronous) clears counters, queue and valid flags.
// An m_ stall fills the queue, after which s_ready drops; no beat is lost.
`default_nettype none
module window_rank_numbering_core (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire                s_partition_start,
    input  wire                s_ties_previous,
    input  wnr_pkg::row_t      s_partition_rows,
    output logic               m_valid,
    input  wire                m_ready,
    output wnr_pkg::row_t      m_row_index,
    output wnr_pkg::row_t      m_gap_rank,
    output wnr_pkg::row_t      m_compact_rank,
    output wnr_pkg::pct_t      m_frac_rank
);
    import wnr_pkg::*;

    // front -> queue
    logic       push_valid, push_ready;
    work_item_t push_item;
    // queue -> back
    logic       pop_valid, pop_ready;
    work_item_t pop_item;

    // Rank counters; classifies each row as zero / full / divide.
    wnr_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_partition_start (s_partition_start),
        .s_ties_previous   (s_ties_previous),
        .s_partition_rows  (s_partition_rows),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_item         (push_item)
    );

    // Decouples the counters from the slow divider.
    wnr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Percent-rank divider and output register.
    wnr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_item       (pop_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_index    (m_row_index),
        .m_gap_rank     (m_gap_rank),
        .m_compact_rank (m_compact_rank),
        .m_frac_rank    (m_frac_rank)
    );

endmodule
`default_nettype wire

>>> sv/wnr_checker.sv
`default_nettype none
`include "window_rank_numbering_core_defines.svh"
module wnr_checker (
    input wire                aclk,
    input wire                aresetn,
    input wire                s_valid,
    input wire                s_ready,
    input wire                s_partition_start,
    input wire                s_ties_previous,
    input wnr_pkg::row_t      s_partition_rows,
    input wire                m_valid,
    input wire                m_ready,
    input wnr_pkg::row_t      m_row_index,
    input wnr_pkg::row_t      m_gap_rank,
    input wnr_pkg::row_t      m_compact_rank,
    input wnr_pkg::pct_t      m_frac_rank
);
    import wnr_pkg::*;

    logic [ROW_BITS+1:0] s_payload;
    logic                order_ok;
    logic                first_ok;

    assign s_payload = {s_partition_start, s_ties_previous, s_partition_rows};
    assign order_ok  = (m_gap_rank <= m_row_index) && (m_compact_rank <= m_gap_rank);
    assign first_ok  = (m_gap_rank == row_t'(1)) && (m_compact_rank == row_t'(1))
                       && (m_frac_rank == '0);

    `WRN_ASSERT_NEXT(a_s_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_payload))
    `WRN_ASSERT_NEXT(a_m_valid_holds, aclk, aresetn, m_valid && !m_ready, m_valid)
    `WRN_ASSERT_NOW(a_rank_order, aclk, aresetn, m_valid, order_ok)
    `WRN_ASSERT_NOW(a_first_row, aclk, aresetn, m_valid && (m_row_index == row_t'(1)), first_ok)
    `WRN_ASSERT_NOW(a_pct_range, aclk, aresetn, m_valid, m_frac_rank <= PCT_ONE)

endmodule

bind window_rank_numbering_core wnr_checker u_wnr_checker (.*);
`default_nettype wire

>>> test/tb_window_rank_numbering_core.sv
module tb_window_rank_numbering_core;
    import wnr_pkg::*;

    // Expected beat on the m_ channel.
    typedef struct packed {
        row_t row_index;
        row_t gap_rank;
        row_t compact_rank;
        pct_t frac_rank;
    } rank_beat_t;

    // One directed row. When 'typed' is set, the expected beat is given here
    // and not taken from the ranking model.
    typedef struct packed {
        bit   start;
        bit   ties;
        row_t rows;
        bit   typed;
        row_t row_index;
        row_t gap_rank;
        row_t compact_rank;
        pct_t frac_rank;
    } dir_row_t;

    // Handshake pressure profile, rotated over the random part.
    typedef enum int {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SINK_STALL,
        PH_BOTH
    } idle_phase_t;

    localparam int DRAIN_CYCLES  = 40;   // idle cycles after the last drain
    localparam int HOLD_CYCLES   = 300;  // long sink hold-off
    localparam int HOLD_AT_ROW   = 250;  // input beats accepted before the hold-off
    localparam int CHUNKS        = 8;
    localparam int CHUNK_ROWS    = 100;
    localparam int REPORT_LIMIT  = 10;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic s_partition_start;
    logic s_ties_previous;
    row_t s_partition_rows;
    logic m_valid;
    logic m_ready;
    row_t m_row_index;
    row_t m_gap_rank;
    row_t m_compact_rank;
    pct_t m_frac_rank;

    window_rank_numbering_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_partition_start (s_partition_start),
        .s_ties_previous   (s_ties_previous),
        .s_partition_rows  (s_partition_rows),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_row_index       (m_row_index),
        .m_gap_rank        (m_gap_rank),
        .m_compact_rank    (m_compact_rank),
        .m_frac_rank       (m_frac_rank)
    );

    // 20-unit clock period.
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Ranking model: running counters of the current partition.
    // ------------------------------------------------------------------
    row_t        rank_pos;      // row number of last row, 0 = nothing seen yet
    row_t        rank_gap;      // gap rank of last row
    row_t        rank_dense;    // dense rank of last row

    rank_beat_t  pending_ranks[$];   // beats expected on m_, oldest first
    idle_phase_t idle_phase;
    int          rows_sent;          // accepted s_ beats
    int          fail_count;

    function automatic row_t sat_bump(row_t v);
        return (v == ROW_MAX) ? v : v + row_t'(1);
    endfunction

    // (rank-1)/(rows-1) in Q1.FRACTION_BITS, truncated, clamped to 1.0.
    function automatic pct_t frac_rank_of(row_t rank, row_t rows);
        logic [63:0] num;
        logic [63:0] den;
        if (rows <= row_t'(1) || rank == row_t'(0))
            return '0;
        num = 64'(rank) - 64'd1;
        den = 64'(rows) - 64'd1;
        if (num >= den)
            return PCT_ONE;
        return pct_t'((num << FRACTION_BITS) / den);
    endfunction

    // Advance the counters by one row and return the beat it produces.
    function automatic rank_beat_t rank_next_row(bit start, bit ties, row_t rows);
        rank_beat_t beat;
        // The very first row after reset opens a partition regardless of
        // the start flag; a start flag overrides the tie flag.
        if (start || rank_pos == row_t'(0)) begin
            rank_pos   = 1;
            rank_gap   = 1;
            rank_dense = 1;
        end else begin
            rank_pos = sat_bump(rank_pos);
            if (!ties) begin
                // New tie group: rank jumps to its position.
                rank_gap   = rank_pos;
                rank_dense = sat_bump(rank_dense);
            end
        end
        beat.row_index    = rank_pos;
        beat.gap_rank     = rank_gap;
        beat.compact_rank = rank_dense;
        beat.frac_rank    = frac_rank_of(rank_gap, rows);
        return beat;
    endfunction

    // ------------------------------------------------------------------
    // Source side: offer one row, hold it until the s_ beat is taken.
    // ------------------------------------------------------------------
    task automatic offer_row(input bit start, input bit ties, input row_t rows,
                             input bit typed, input rank_beat_t want);
        rank_beat_t predicted;
        // Random idle cycles in front of the beat, per current phase.
        while ($urandom_range(99) < ((idle_phase == PH_SRC_IDLE) ? 65 :
                                     (idle_phase == PH_BOTH) ? 14 : 0)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_partition_start <= start;
        s_ties_previous   <= ties;
        s_partition_rows  <= rows;
        // Values read right after the edge are the ones the DUT sampled.
        do
            @(posedge aclk);
        while (!s_ready);
        predicted = rank_next_row(start, ties, rows);
        pending_ranks.push_back(typed ? want : predicted);
        rows_sent++;
    endtask

    task automatic drain_pending();
        while (pending_ranks.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Sink side: random stalls per phase, plus one long hold-off once the
    // source has pushed HOLD_AT_ROW beats, so the queue fills and s_ready
    // drops while the source keeps offering.
    // ------------------------------------------------------------------
    initial begin
        int         hold_left;
        bit         hold_done;
        rank_beat_t want;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_ranks.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected rank beat: row %0d gap %0d dense %0d pct %0d",
                                 m_row_index, m_gap_rank, m_compact_rank, m_frac_rank);
                end else begin
                    want = pending_ranks.pop_front();
                    if (m_row_index != want.row_index || m_gap_rank != want.gap_rank ||
                        m_compact_rank != want.compact_rank ||
                        m_frac_rank != want.frac_rank) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("rank mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     want.row_index, want.gap_rank, want.compact_rank,
                                     want.frac_rank, m_row_index, m_gap_rank,
                                     m_compact_rank, m_frac_rank);
                    end
                end
            end
            if (!hold_done && rows_sent >= HOLD_AT_ROW) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= ((idle_phase == PH_SINK_STALL) ? 65 :
                                                   (idle_phase == PH_BOTH) ? 14 : 0));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, then random partitions.
    // ------------------------------------------------------------------
    initial begin
        dir_row_t   directed [21];
        rank_beat_t want;
        int         pick;
        int         count;
        int         emitted;
        row_t       rows_val;

        rank_pos   = '0;
        rank_gap   = '0;
        rank_dense = '0;
        rows_sent  = 0;
        fail_count = 0;
        idle_phase = PH_STEADY;

        s_valid           <= 1'b0;
        s_partition_start <= 1'b0;
        s_ties_previous   <= 1'b0;
        s_partition_rows  <= '0;
        aresetn           <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // start, ties, rows, typed, row, gap, dense, pct
        directed = '{
            // first row after reset opens a partition without the start flag
            '{1'b0, 1'b1, 32'd1,          1'b1, 32'd1, 32'd1, 32'd1, 17'd0},
            // one-row count gives zero percent rank
            '{1'b0, 1'b0, 32'd1,          1'b1, 32'd2, 32'd2, 32'd2, 17'd0},
            // zero row count, tied row keeps its rank
            '{1'b0, 1'b1, 32'd0,          1'b1, 32'd3, 32'd2, 32'd2, 17'd0},
            // rank past the row count clamps to 1.0
            '{1'b0, 1'b0, 32'd2,          1'b1, 32'd4, 32'd4, 32'd3, PCT_ONE},
            // partition start ignores the tie flag
            '{1'b1, 1'b1, 32'd5,          1'b1, 32'd1, 32'd1, 32'd1, 17'd0},
            '{1'b0, 1'b0, 32'd5,          1'b0, 32'd0, 32'd0, 32'd0, 17'd0},
            '{1'b0, 1'b1, 32'd5,          1'b0, 32'd0, 32'd0, 32'd0, 17'd0},
            '{1'b0, 1'b0, 32'd5,          1'b0, 32'd0, 32'd0, 32'd0, 17'd0},
            '{1'b0, 1'b0, 32'd5,          1'b0, 32'd0, 32'd0, 32'd0, 17'd0},
            // largest row count
            '{1'b1, 1'b0, 32'hFFFF_FFFF,  1'b1, 32'd1, 32'd1, 32'd1, 17'd0},
            '{1'b0, 1'b0, 32'hFFFF_FFFF,  1'b0, 32'd0, 32'd0, 32'd0, 17'd0},
            '{1'b0, 1'b1, 32'hFFFF_FFFF,  1'b0, 32'd0, 32'd0, 32'd0, 17'd0},
            '{1'b1, 1'b0, 32'd3,          1'b1, 32'd1, 32'd1, 32'd1, 17'd0},
            '{1'b0, 1'b0, 32'd3,          1'b0, 32'd0, 32'd0, 32'd0, 17'd0},
            '{1'b0, 1'b0, 32'd3,          1'b0, 32'd0, 32'd0, 32'd0, 17'd0},
            // alternating bit patterns, row count changing mid-partition
            '{1'b1, 1'b1, 32'hAAAA_AAAA,  1'b0, 32'd0, 32'd0, 32'd0, 17'd0},
            '{1'b0, 1'b0, 32'h5555_5555,  1'b0, 32'd0, 32'd0, 32'd0, 17'd0},
            '{1'b0, 1'b1, 32'h5555_5555,  1'b0, 32'd0, 32'd0, 32'd0, 17'd0},
            '{1'b1, 1'b0, 32'd2,          1'b0, 32'd0, 32'd0, 32'd0, 17'd0},
            '{1'b0, 1'b1, 32'd2,          1'b0, 32'd0, 32'd0, 32'd0, 17'd0},
            '{1'b0, 1'b0, 32'd2,          1'b0, 32'd0, 32'd0, 32'd0, 17'd0}
        };

        foreach (directed[i]) begin
            want.row_index    = directed[i].row_index;
            want.gap_rank     = directed[i].gap_rank;
            want.compact_rank = directed[i].compact_rank;
            want.frac_rank    = directed[i].frac_rank;
            offer_row(directed[i].start, directed[i].ties, directed[i].rows,
                      directed[i].typed, want);
        end
        s_valid <= 1'b0;
        drain_pending();

        // Random part: mostly well-formed partitions, some noise rows.
        want = '0;
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            idle_phase = idle_phase_t'(chunk % 4);
            emitted = 0;
            while (emitted < CHUNK_ROWS) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    // noise: any flags, any count including zero
                    rows_val = ($urandom_range(3) == 0) ? row_t'(0) : row_t'($urandom);
                    offer_row($urandom_range(1) == 1, $urandom_range(1) == 1, rows_val,
                              1'b0, want);
                    emitted++;
                end else begin
                    if (pick < 60) begin
                        count    = $urandom_range(1, 8);
                        rows_val = row_t'(count);
                    end else if (pick < 82) begin
                        count    = $urandom_range(9, 40);
                        rows_val = row_t'(count);
                    end else if (pick < 90) begin
                        count    = 1;
                        rows_val = 1;
                    end else begin
                        // huge partition: only its first rows are sent
                        count    = $urandom_range(1, 6);
                        rows_val = row_t'($urandom);
                    end
                    for (int k = 0; k < count; k++)
                        offer_row(k == 0,
                                  (k == 0) ? ($urandom_range(1) == 1)
                                           : ($urandom_range(99) < 40),
                                  rows_val, 1'b0, want);
                    emitted += count;
                end
            end
            // Source pauses until every pending beat is back.
            s_valid <= 1'b0;
            drain_pending();
        end

        idle_phase = PH_STEADY;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_ranks.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard limit on run time.
    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/wnr_pkg.sv
sv/wnr_front.sv
sv/wnr_queue.sv
sv/wnr_back.sv
sv/window_rank_numbering_core.sv
sv/wnr_checker.sv
test/tb_window_rank_numbering_core.sv
